>>> rtl/tagged_argument_stream_decoder_defines.svh
// Assertion macros for the decoder RTL.
`ifndef TAGGED_ARGUMENT_STREAM_DECODER_DEFINES_SVH
`define TAGGED_ARGUMENT_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TASD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TASD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tasd_pkg.sv
// Types and constants shared by the tagged argument stream decoder.
`default_nettype none

package tasd_pkg;

    localparam int CHAR_W = 16;
    localparam int INT_W  = 32;

    localparam logic [CHAR_W-1:0] CH_INT   = 16'h0069;  // 'i'
    localparam logic [CHAR_W-1:0] CH_END   = 16'h0073;  // 's'
    localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;  // ':'
    localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;  // '-'
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;  // '9'

    localparam logic [INT_W-1:0] INT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [INT_W-1:0] INT_MAG_CAP = 32'h8000_0000;

    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_LEN        = 3'd1,
        PH_BODY       = 3'd2,
        PH_INT_FIRST  = 3'd3,
        PH_INT_DIGITS = 3'd4,
        PH_LEN_BAD    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_STR_CHAR  = 2'd0,
        KIND_STR_EMPTY = 2'd1,
        KIND_INT       = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  string_char;
        logic               is_last;
        logic signed [INT_W-1:0] int_value;
    } result_t;

    typedef struct packed {
        logic    load;
        result_t res;
    } result_load_t;

endpackage

`default_nettype wire

>>> rtl/tasd_in_stage.sv
// Input register of the decoder: holds one character transaction.
`default_nettype none

module tasd_in_stage
    import tasd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic              take,
    output logic                   in_stall,
    output item_t                  item
);

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;

    assign in_stall = valid_reg && !take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && !in_stall)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_code;
        end
    end

    assign item.valid     = valid_reg;
    assign item.char_code = char_reg;

endmodule

`default_nettype wire

>>> rtl/tasd_parser.sv
// Token parser: phase state, length and integer accumulators, result decode.
`default_nettype none

module tasd_parser
    import tasd_pkg::*;
#(
    parameter int LENGTH_BITS = 24,
    parameter int CHAR_BITS   = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire item_t  item,
    input  wire logic   slot_free,
    output logic        take,
    output result_load_t load,
    output phase_t      phase
);

    localparam int CW = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
    localparam logic [CHAR_W:0] MASK_WIDE = (CHAR_W + 1)'((1 << CW) - 1);
    localparam logic [CHAR_W-1:0] CHAR_MASK = MASK_WIDE[CHAR_W-1:0];

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [LENGTH_BITS-1:0]  len_reg;
    logic [LENGTH_BITS-1:0]  len_next;
    logic [LENGTH_BITS-1:0]  rem_reg;
    logic [LENGTH_BITS-1:0]  rem_next;
    logic [INT_W-1:0]        int_reg;
    logic [INT_W-1:0]        int_next;
    logic                    neg_reg;
    logic                    neg_next;

    logic [CHAR_W-1:0]       c;
    logic                    is_dig;
    logic [3:0]              dig;
    logic [LENGTH_BITS+3:0]  len_wide;
    logic                    len_ovf;
    logic [INT_W+3:0]        int_wide;
    logic [INT_W-1:0]        int_sat;
    logic [INT_W-1:0]        int_out;
    logic                    produce;
    result_t                 res;

    assign c      = item.char_code & CHAR_MASK;
    assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dig    = c[3:0];

    // multiply by ten as two shifts and an add
    assign len_wide = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1)
                    + (LENGTH_BITS + 4)'(dig);
    assign len_ovf  = |len_wide[LENGTH_BITS+3:LENGTH_BITS];

    assign int_wide = ({4'b0, int_reg} << 3) + ({4'b0, int_reg} << 1)
                    + (INT_W + 4)'(dig);
    assign int_sat  = (int_wide > {4'b0, INT_MAG_CAP}) ? INT_MAG_CAP : int_wide[INT_W-1:0];

    // magnitude never exceeds 2^31, so bit 31 alone marks positive overflow
    assign int_out = neg_reg ? (INT_W'(0) - int_reg)
                             : (int_reg[INT_W-1] ? INT_POS_MAX : int_reg);

    // result decode
    always_comb
    begin
        produce         = 1'b0;
        res.kind        = KIND_ERROR;
        res.string_char = '0;
        res.is_last     = 1'b0;
        res.int_value   = '0;
        case (phase_reg)
            PH_START:
            begin
                if ((c != CH_INT) && !is_dig)
                begin
                    produce = 1'b1;
                end
            end
            PH_LEN:
            begin
                if (is_dig)
                begin
                    produce = len_ovf;
                end
                else if (c == CH_COLON)
                begin
                    if (len_reg == '0)
                    begin
                        produce  = 1'b1;
                        res.kind = KIND_STR_EMPTY;
                    end
                end
                else
                begin
                    produce = 1'b1;
                end
            end
            PH_BODY:
            begin
                produce         = 1'b1;
                res.kind        = KIND_STR_CHAR;
                res.string_char = c;
                res.is_last     = (rem_reg <= LENGTH_BITS'(1));
            end
            PH_INT_FIRST, PH_INT_DIGITS:
            begin
                if (!is_dig && !((phase_reg == PH_INT_FIRST) && (c == CH_MINUS)))
                begin
                    produce = 1'b1;
                    if (c == CH_END)
                    begin
                        res.kind      = KIND_INT;
                        res.int_value = int_out;
                    end
                end
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        int_next   = int_reg;
        neg_next   = neg_reg;
        case (phase_reg)
            PH_START:
            begin
                if (c == CH_INT)
                begin
                    int_next   = '0;
                    neg_next   = 1'b0;
                    phase_next = PH_INT_FIRST;
                end
                else if (is_dig)
                begin
                    len_next   = LENGTH_BITS'(dig);
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (is_dig)
                begin
                    if (len_ovf)
                    begin
                        len_next   = '0;
                        phase_next = PH_LEN_BAD;
                    end
                    else
                    begin
                        len_next = len_wide[LENGTH_BITS-1:0];
                    end
                end
                else if (c == CH_COLON)
                begin
                    if (len_reg == '0)
                    begin
                        phase_next = PH_START;
                    end
                    else
                    begin
                        rem_next   = len_reg;
                        len_next   = '0;
                        phase_next = PH_BODY;
                    end
                end
                else
                begin
                    len_next   = '0;
                    phase_next = PH_START;
                end
            end
            PH_BODY:
            begin
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - LENGTH_BITS'(1);
                end
                if (rem_reg <= LENGTH_BITS'(1))
                begin
                    phase_next = PH_START;
                end
            end
            PH_INT_FIRST, PH_INT_DIGITS:
            begin
                if ((phase_reg == PH_INT_FIRST) && (c == CH_MINUS))
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT_DIGITS;
                end
                else if (is_dig)
                begin
                    int_next   = int_sat;
                    phase_next = PH_INT_DIGITS;
                end
                else
                begin
                    phase_next = PH_START;
                end
            end
            PH_LEN_BAD:
            begin
                if (!is_dig)
                begin
                    phase_next = PH_START;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    // an item with no result moves on even while the result slot is full
    assign take = item.valid && (slot_free || !produce);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            len_reg   <= '0;
            rem_reg   <= '0;
            int_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            int_reg   <= int_next;
            neg_reg   <= neg_next;
        end
    end

    assign load.load = take && produce;
    assign load.res  = res;
    assign phase     = phase_reg;

endmodule

`default_nettype wire

>>> rtl/tasd_out_stage.sv
// Result register of the decoder: holds one token transaction for the sink.
`default_nettype none

module tasd_out_stage
    import tasd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire result_load_t load,
    input  wire logic         out_stall,
    output logic              slot_free,
    output logic              out_valid,
    output result_t           res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign slot_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load.load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            res_reg <= load.res;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> rtl/tagged_argument_stream_decoder.sv
// From input transaction to result: input register, then result register.
// Throughput: one character per cycle unless a character with a token meets a
//   stalled, full result register; the parser's phase and accumulator update sets this rate.
// A character that yields no token still moves on while the result is stalled.
// Reset (rst_n low, asynchronous): parser at token start, accumulators cleared,
//   input and result registers empty.
`default_nettype none

`include "tagged_argument_stream_decoder_defines.svh"

module tagged_argument_stream_decoder
    import tasd_pkg::*;
#(
    parameter int LENGTH_BITS = 24,   // string length field width, 8 to 32
    parameter int CHAR_BITS   = 16    // significant bits of a character, 8 to 32
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [CHAR_W-1:0]        char_code,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    token_kind,
    output logic [CHAR_W-1:0]             string_char,
    output logic                          is_last_char,
    output logic signed [INT_W-1:0]       int_value
);

    item_t        item;
    logic         take;
    logic         slot_free;
    result_load_t load;
    phase_t       phase;
    result_t      res;

    // Input register: one character transaction waiting for the parser.
    tasd_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .char_code (char_code),
        .take      (take),
        .in_stall  (in_stall),
        .item      (item)
    );

    // Parser: one character per cycle unless its token meets a stalled, full result slot; state advances on take.
    tasd_parser #(
        .LENGTH_BITS (LENGTH_BITS),
        .CHAR_BITS   (CHAR_BITS)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .slot_free (slot_free),
        .take      (take),
        .load      (load),
        .phase     (phase)
    );

    // Result register: decouples the sink's stall from the parser.
    tasd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .out_stall (out_stall),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .res       (res)
    );

    assign token_kind   = res.kind;
    assign string_char  = res.string_char;
    assign is_last_char = res.is_last;
    assign int_value    = res.int_value;

    // The last character of a string body sends the parser back to token start.
    `TASD_ASSERT_NEXT(a_last_ends_body, load.load && load.res.is_last, phase == PH_START, "last string char did not return to token start")

    // Only string-character tokens carry a character or a last mark.
    `TASD_ASSERT_NOW(a_char_only_str, out_valid && (token_kind != KIND_STR_CHAR), (string_char == '0) && !is_last_char, "char field set on non-string token")

    // Only integer tokens carry a value.
    `TASD_ASSERT_NOW(a_value_only_int, out_valid && (token_kind != KIND_INT), int_value == '0, "value set on non-integer token")

    // A result is never loaded into a full, stalled result register.
    `TASD_ASSERT_NOW(a_no_overwrite, load.load, !out_valid || !out_stall, "result overwritten while stalled")

endmodule

`default_nettype wire

>>> tb/tagged_argument_stream_decoder_tb.sv
// Self-checking testbench for the tagged argument stream decoder: directed tokens, random streams.
`default_nettype none

module tagged_argument_stream_decoder_tb;
    import tasd_pkg::*;

    localparam int LEN_BITS    = 24;
    localparam logic [39:0] LEN_MAX = (40'd1 << LEN_BITS) - 40'd1;
    localparam logic [39:0] MAG_CAP = 40'h00_8000_0000;   // magnitude stops at 2^31
    localparam int HOLD_CYCLES = 300;                     // long result-side hold-off
    localparam int QUIET_LIMIT = 2000;                    // watchdog: cycles with no transaction
    localparam int DRAIN_CYCLES = 10;                     // settle margin after the owed tokens are out

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic [CHAR_W-1:0]       char_code = '0;
    logic                    out_stall = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic [1:0]              token_kind;
    logic [CHAR_W-1:0]       string_char;
    logic                    is_last_char;
    logic signed [INT_W-1:0] int_value;

    // Traffic shaping, set by the test tasks.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned chars_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // Tokens the decoder owes us, oldest first.
    result_t expected_tokens[$];

    // Shadow parser state.
    phase_t      parse_ph = PH_START;
    logic [39:0] len_acc  = '0;
    logic [39:0] body_left = '0;
    logic [39:0] mag_acc  = '0;
    logic        neg      = 1'b0;

    tagged_argument_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .string_char  (string_char),
        .is_last_char (is_last_char),
        .int_value    (int_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_digit_char(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
        return CH_ZERO + CHAR_W'(d);
    endfunction

    // Advance the shadow parser by one character; returns 1 when a token comes out.
    function automatic bit decode_char(input logic [CHAR_W-1:0] c, output result_t tok);
        logic [39:0] digit;
        logic [39:0] n;
        logic [39:0] m;
        bit          last;
        digit = 40'(c - CH_ZERO);
        tok   = '0;
        case (parse_ph)
            PH_START:
            begin
                if (c == CH_INT)
                begin
                    mag_acc  = '0;
                    neg      = 1'b0;
                    parse_ph = PH_INT_FIRST;
                    return 1'b0;
                end
                if (is_digit_char(c))
                begin
                    len_acc  = digit;
                    parse_ph = PH_LEN;
                    return 1'b0;
                end
                // bad token start: character dropped, still at token start
                tok.kind = KIND_ERROR;
                return 1'b1;
            end
            PH_LEN:
            begin
                if (is_digit_char(c))
                begin
                    n = len_acc * 10 + digit;
                    if (n > LEN_MAX)
                    begin
                        len_acc  = '0;
                        parse_ph = PH_LEN_BAD;
                        tok.kind = KIND_ERROR;
                        return 1'b1;
                    end
                    len_acc = n;
                    return 1'b0;
                end
                if (c == CH_COLON)
                begin
                    if (len_acc == 0)
                    begin
                        parse_ph = PH_START;
                        tok.kind = KIND_STR_EMPTY;
                        return 1'b1;
                    end
                    body_left = len_acc;
                    len_acc   = '0;
                    parse_ph  = PH_BODY;
                    return 1'b0;
                end
                len_acc  = '0;
                parse_ph = PH_START;
                tok.kind = KIND_ERROR;
                return 1'b1;
            end
            PH_BODY:
            begin
                last = body_left <= 1;
                if (body_left > 0)
                    body_left = body_left - 1;
                if (last)
                    parse_ph = PH_START;
                tok.kind        = KIND_STR_CHAR;
                tok.string_char = c;
                tok.is_last     = last;
                return 1'b1;
            end
            PH_INT_FIRST, PH_INT_DIGITS:
            begin
                if (parse_ph == PH_INT_FIRST && c == CH_MINUS)
                begin
                    neg      = 1'b1;
                    parse_ph = PH_INT_DIGITS;
                    return 1'b0;
                end
                if (is_digit_char(c))
                begin
                    n        = mag_acc * 10 + digit;
                    mag_acc  = (n > MAG_CAP) ? MAG_CAP : n;
                    parse_ph = PH_INT_DIGITS;
                    return 1'b0;
                end
                parse_ph = PH_START;
                if (c != CH_END)
                begin
                    tok.kind = KIND_ERROR;
                    return 1'b1;
                end
                tok.kind = KIND_INT;
                if (neg)
                begin
                    m = (mag_acc > MAG_CAP) ? MAG_CAP : mag_acc;
                    tok.int_value = INT_W'(40'd0 - m);
                end
                else
                    tok.int_value = (mag_acc > 40'(INT_POS_MAX)) ? INT_POS_MAX
                                                                 : INT_W'(mag_acc);
                return 1'b1;
            end
            PH_LEN_BAD:
            begin
                // oversize length: digits swallowed, anything else back to token start
                if (!is_digit_char(c))
                    parse_ph = PH_START;
                return 1'b0;
            end
            default:
            begin
                parse_ph = PH_START;
                return 1'b0;
            end
        endcase
    endfunction

    // One input transaction. Valid stays high across back-to-back characters.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        result_t tok;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (decode_char(c, tok))
            expected_tokens.push_back(tok);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char({8'h00, s[i]});
    endtask

    // Mix of full-range characters and the ones the parser cares about.
    function automatic logic [CHAR_W-1:0] noise_char();
        if ($urandom_range(0, 1) == 0)
            return CHAR_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0:       return CH_COLON;
            1:       return CH_INT;
            2:       return CH_END;
            3:       return CH_MINUS;
            4:       return CH_ZERO;
            5:       return CH_NINE;
            6:       return 16'hFFFF;
            default: return 16'h0020;
        endcase
    endfunction

    // Push the parser back to token start so a directed test begins clean.
    task automatic finish_open_token();
        while (parse_ph != PH_START)
            send_char(16'h0020);
    endtask

    task automatic send_string_token(input int unsigned len);
        if ($urandom_range(0, 9) == 0)
            send_char(CH_ZERO);                       // leading zero in the length
        send_text($sformatf("%0d", len));
        if ($urandom_range(0, 11) == 0)
        begin
            send_char(noise_char());                  // broken: junk in the length
            // a junk digit must not glue onto the next length
            if (parse_ph == PH_LEN)
                send_char(16'h0020);
            return;
        end
        send_char(CH_COLON);
        for (int i = 0; i < len; i++)
            send_char($urandom_range(0, 9) < 7 ? CHAR_W'($urandom_range(0, 65535))
                                               : CHAR_W'($urandom_range(32, 126)));
    endtask

    task automatic send_random_token();
        int unsigned pick;
        int unsigned ndig;
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            ndig = $urandom_range(0, 99);
            if (ndig < 10)
                send_string_token(0);
            else if (ndig < 85)
                send_string_token($urandom_range(1, 8));
            else
                send_string_token($urandom_range(9, 40));
        end
        else if (pick < 76)
        begin
            send_char(CH_INT);
            if ($urandom_range(0, 9) < 4)
                send_char(CH_MINUS);
            ndig = $urandom_range(0, 99);
            ndig = (ndig < 15) ? 0 : (ndig < 75) ? $urandom_range(1, 9)
                                                 : $urandom_range(10, 12);
            for (int i = 0; i < ndig; i++)
                send_char(digit_char($urandom_range(0, 9)));
            send_char($urandom_range(0, 9) == 0 ? noise_char() : CH_END);
        end
        else if (pick < 84)
        begin
            // leading digit of 2 or more makes eight digits overflow the length field
            send_char(digit_char($urandom_range(2, 9)));
            ndig = 7 + $urandom_range(0, 2);
            for (int i = 0; i < ndig; i++)
                send_char(digit_char($urandom_range(0, 9)));
            send_char($urandom_range(0, 9) < 7 ? CH_COLON : noise_char());
        end
        else
        begin
            ndig = $urandom_range(1, 3);
            for (int i = 0; i < ndig; i++)
                send_char(noise_char());
            // a stray digit must not glue onto the next length
            if (parse_ph == PH_LEN)
                send_char(16'h0020);
        end
    endtask

    task automatic test_string_tokens();
        finish_open_token();
        send_text("0:");                              // empty string
        send_text("2:");
        send_char(16'hFFFF);
        send_char(16'h0000);
    endtask

    task automatic test_integer_tokens();
        finish_open_token();
        send_text("is");                              // no digits gives zero
        send_text("i-9999999999s");                   // negative saturation
    endtask

    task automatic test_malformed_input();
        finish_open_token();
        send_char(16'hFFFF);                          // bad token start
        send_text("1x");                              // junk inside a length
        send_text("i-:");                             // junk inside an integer
        send_text("167772160:");                      // oversize length, extra digit ignored
    endtask

    task automatic test_random_stream(input int unsigned idle, input int unsigned stall,
                                      input int unsigned count);
        int unsigned stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = chars_sent + count;
        while (chars_sent < stop_at)
            send_random_token();
    endtask

    // Receiver holds off while a long string keeps coming, so the decoder backs up.
    task automatic test_output_hold_off();
        idle_pct  = 0;
        stall_pct = 0;
        finish_open_token();
        hold_reqs++;
        send_string_token(30);
        send_text("i-42s");
        send_string_token(12);
    endtask

    // Random tokens, then the sender goes quiet until every owed token has come out, then more.
    task automatic test_pause_until_drained();
        int unsigned stop_at;
        idle_pct  = 0;
        stall_pct = 47;
        stop_at   = chars_sent + 40;
        while (chars_sent < stop_at)
            send_random_token();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        stop_at = chars_sent + 40;
        while (chars_sent < stop_at)
            send_random_token();
    endtask

    // Result-side stall: random, or a counted hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each output transaction against the oldest owed token.
    always @(posedge clk)
    begin : check_tokens
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected token: kind %0d char %h last %b value %0d",
                             token_kind, string_char, is_last_char, int_value);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (token_kind !== want.kind || string_char !== want.string_char ||
                    is_last_char !== want.is_last || int_value !== want.int_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"token mismatch: kind %0d/%0d char %h/%h last %b/%b ",
                                  "value %0d/%0d (expected/actual)"},
                                 want.kind, token_kind, want.string_char, string_char,
                                 want.is_last, is_last_char, want.int_value, int_value);
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tagged_argument_stream_decoder regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_string_tokens();
        test_integer_tokens();
        test_malformed_input();
        test_random_stream(0, 0, 380);
        test_random_stream(47, 0, 380);
        test_random_stream(0, 47, 380);
        test_random_stream(20, 20, 380);
        test_output_hold_off();
        test_pause_until_drained();

        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("tagged_argument_stream_decoder regression: pass");
        else
            $display("tagged_argument_stream_decoder regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
